// File: rtl/pressure_average_peak_tracker_top_assert.svh
// Assertion macros for the pressure average and peak tracker checker.
// Used by pap_checker; expects i_clk and i_rst_n in the including scope.
`ifndef PRESSURE_AVERAGE_PEAK_TRACKER_TOP_ASSERT_SVH
`define PRESSURE_AVERAGE_PEAK_TRACKER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define PAP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/pap_pkg.sv
// Shared constants and types for the pressure average and peak tracker.
// No dependencies; imported by every RTL module of the block.
package pap_pkg;

    // Sensor count and calibration register.
    localparam int COUNT_W = 14;
    localparam logic [COUNT_W-1:0] ZERO_COUNT_RESET = 14'd1638;
    localparam logic [5:0] COUNT_MASK = 6'h3F;

    // Gain of about 1.99167 per count, held as Q16 rounded to nearest.
    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] GAIN_Q16 = 17'd130526;
    localparam int GAIN_SHIFT = 16;
    localparam int PROD_W = COUNT_W + GAIN_W;

    // Result field widths.
    localparam int PRESS_W = 16;
    localparam int PEAK_W = 15;

    // Scaled reading between the scaling and window stages.
    typedef struct packed {
        logic               read_ok;
        logic               neg;
        logic [PROD_W-1:0]  prod;
    } t_scaled;

    // Per-request results between the window and averaging stages.
    typedef struct packed {
        logic                       read_ok;
        logic signed [PRESS_W-1:0]  pressure;
        logic [PEAK_W-1:0]          peak;
    } t_win_res;

endpackage

// File: rtl/pap_in_if.sv
// Input channel of the tracker: one raw sensor reading per request.
// Depends on nothing.
interface pap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
    logic       read_ok;

    modport source (output valid, high_byte, low_byte, read_ok, input ready);
    modport sink   (input valid, high_byte, low_byte, read_ok, output ready);
endinterface

// File: rtl/pap_out_if.sv
// Output channel of the tracker: pressure, window average, peak and error.
// Depends on pap_pkg for the field widths.
interface pap_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pap_pkg::PRESS_W-1:0] pressure;
    logic signed [pap_pkg::PRESS_W-1:0] window_average;
    logic [pap_pkg::PEAK_W-1:0]         peak_pressure;
    logic                               read_error;

    modport source (output valid, pressure, window_average, peak_pressure, read_error,
                    input ready);
    modport sink   (input valid, pressure, window_average, peak_pressure, read_error,
                    output ready);
endinterface

// File: rtl/pap_cfg_if.sv
// Configuration write channel of the tracker: the zero-pressure count.
// Depends on pap_pkg for the count width.
interface pap_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pap_pkg::COUNT_W-1:0]  zero_count;

    modport source (output valid, zero_count, input ready);
    modport sink   (input valid, zero_count, output ready);
endinterface

// File: rtl/pap_scale.sv
// Input register and gain multiplier: raw count to scaled magnitude product.
// Depends on pap_pkg.
module pap_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pap_pkg::COUNT_W-1:0] i_zero_count,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_high_byte,
    input  logic [7:0]                  i_low_byte,
    input  logic                        i_read_ok,
    output logic                        o_valid,
    input  logic                        i_ready,
    output pap_pkg::t_scaled            o_scaled
);
    import pap_pkg::*;

    logic                       r_v1;
    logic                       r_v2;
    logic [7:0]                 r_high_byte;
    logic [7:0]                 r_low_byte;
    logic                       r_read_ok;
    t_scaled                    r_scaled;
    t_scaled                    n_scaled;
    logic                       w_load1;
    logic                       w_load2;
    logic [COUNT_W-1:0]         w_raw;
    logic [COUNT_W:0]           w_diff;
    logic [COUNT_W:0]           w_abs;

    // Each stage loads when it is empty or its content moves on.
    assign w_load2 = !r_v2 || i_ready;
    assign w_load1 = !r_v1 || w_load2;
    assign o_ready = w_load1;
    assign o_valid = r_v2;
    assign o_scaled = r_scaled;

    // Offset correction and gain multiply on the registered reading.
    always_comb begin
        w_raw = {r_high_byte[5:0] & COUNT_MASK, r_low_byte};
        w_diff = {1'b0, w_raw} - {1'b0, i_zero_count};
        w_abs = w_diff[COUNT_W] ? (~w_diff + 1'b1) : w_diff;
        n_scaled.read_ok = r_read_ok;
        n_scaled.neg = w_diff[COUNT_W];
        n_scaled.prod = PROD_W'(w_abs[COUNT_W-1:0]) * PROD_W'(GAIN_Q16);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_load1) begin
                r_v1 <= i_valid;
            end
            if (w_load2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_load1 && i_valid) begin
            r_high_byte <= i_high_byte;
            r_low_byte <= i_low_byte;
            r_read_ok <= i_read_ok;
        end
        if (w_load2 && r_v1) begin
            r_scaled <= n_scaled;
        end
    end

endmodule

// File: rtl/pap_window.sv
// Window stage: sample shift line, running sum and peak hold.
// Depends on pap_pkg.
module pap_window #(
    parameter int WINDOW = 10,
    parameter int SUM_W = pap_pkg::PRESS_W + $clog2(WINDOW)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  pap_pkg::t_scaled         i_scaled,
    output logic                     o_valid,
    input  logic                     i_ready,
    output pap_pkg::t_win_res        o_res,
    output logic signed [SUM_W-1:0]  o_sum
);
    import pap_pkg::*;

    logic signed [PRESS_W-1:0]  r_ring [WINDOW];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [PEAK_W-1:0]          r_peak;
    logic [PEAK_W-1:0]          n_peak;
    logic                       r_v;
    t_win_res                   r_res;
    logic signed [SUM_W-1:0]    r_sum_out;
    logic                       w_take;
    logic                       w_update;
    logic [PEAK_W-1:0]          w_q;
    logic signed [PRESS_W-1:0]  w_p;

    assign o_ready = !r_v || i_ready;
    assign w_take = i_valid && o_ready;
    assign w_update = w_take && i_scaled.read_ok;
    assign o_valid = r_v;
    assign o_res = r_res;
    assign o_sum = r_sum_out;

    // Signed pressure, then the new sum and peak; a failed read keeps both.
    always_comb begin
        w_q = i_scaled.prod[GAIN_SHIFT +: PEAK_W];
        if (!i_scaled.read_ok) begin
            w_p = '0;
        end else if (i_scaled.neg) begin
            w_p = -$signed({1'b0, w_q});
        end else begin
            w_p = $signed({1'b0, w_q});
        end
        n_sum = r_sum;
        n_peak = r_peak;
        if (i_scaled.read_ok) begin
            n_sum = r_sum - SUM_W'(r_ring[WINDOW-1]) + SUM_W'(w_p);
            if (w_p > $signed({1'b0, r_peak})) begin
                n_peak = w_p[PEAK_W-1:0];
            end
        end
    end

    // Window state: the oldest sample leaves at the tail of the line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_sum <= '0;
            r_peak <= '0;
        end else if (w_update) begin
            r_ring[0] <= w_p;
            for (int i = 1; i < WINDOW; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
            r_sum <= n_sum;
            r_peak <= n_peak;
        end
    end

    // Result register valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res.read_ok <= i_scaled.read_ok;
            r_res.pressure <= w_p;
            r_res.peak <= n_peak;
            r_sum_out <= n_sum;
        end
    end

endmodule

// File: rtl/pap_average.sv
// Averaging stage and output register: window sum divided by WINDOW.
// Depends on pap_pkg; the divide is a reciprocal multiply that is exact
// for every sum magnitude the window can hold.
module pap_average #(
    parameter int WINDOW = 10,
    parameter int SUM_W = pap_pkg::PRESS_W + $clog2(WINDOW)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pap_pkg::t_win_res                   i_res,
    input  logic signed [SUM_W-1:0]             i_sum,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pap_pkg::PRESS_W-1:0]  o_pressure,
    output logic signed [pap_pkg::PRESS_W-1:0]  o_window_average,
    output logic [pap_pkg::PEAK_W-1:0]          o_peak_pressure,
    output logic                                o_read_error
);
    import pap_pkg::*;

    // Sum magnitude bits, reciprocal shift and reciprocal constant.
    localparam int MAG_W = SUM_W - 1;
    localparam int RSH = MAG_W + $clog2(WINDOW);
    localparam int RECIP_W = MAG_W + 1;
    localparam longint RECIP_I = ((longint'(1) << RSH) + WINDOW - 1) / WINDOW;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
    localparam int QPROD_W = MAG_W + RECIP_W;

    logic                       r_v;
    logic signed [PRESS_W-1:0]  r_pressure;
    logic signed [PRESS_W-1:0]  r_avg;
    logic [PEAK_W-1:0]          r_peak;
    logic                       r_err;
    logic signed [PRESS_W-1:0]  n_avg;
    logic [SUM_W-1:0]           w_abs;
    logic [QPROD_W-1:0]         w_prod;
    logic [PRESS_W-1:0]         w_q;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_pressure = r_pressure;
    assign o_window_average = r_avg;
    assign o_peak_pressure = r_peak;
    assign o_read_error = r_err;

    // Truncating signed divide: divide the magnitude, then restore the sign.
    always_comb begin
        w_abs = i_sum[SUM_W-1] ? -i_sum : i_sum;
        w_prod = QPROD_W'(w_abs[MAG_W-1:0]) * QPROD_W'(RECIP);
        w_q = w_prod[RSH +: PRESS_W];
        n_avg = i_sum[SUM_W-1] ? -$signed(w_q) : $signed(w_q);
    end

    // Output register valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pressure <= i_res.pressure;
            r_avg <= n_avg;
            r_peak <= i_res.peak;
            r_err <= !i_res.read_ok;
        end
    end

endmodule

// File: rtl/pressure_average_peak_tracker_top.sv
// Pressure average and peak tracker, top level.
// Depends on pap_pkg, the pap_*_if interfaces, pap_scale, pap_window, pap_average.
//
// Usage:
//   i_in carries one raw sensor reading per request (two bytes and read_ok).
//   o_out returns one result per request: signed pressure in 1/256 cmH2O,
//   the truncated average over the last WINDOW good readings, the peak
//   since reset and a read error flag.
//   i_cfg writes the zero-pressure count; it is always ready and should be
//   written only while no request is in flight.
// Timing:
//   Four register stages: input register, gain product, window state and
//   output register. One request is accepted every cycle while the output
//   is not stalled. The window sum and peak updates are the only loops.
// Reset:
//   Synchronous, active low. The sample line, sum and peak clear to zero and
//   the zero count returns to 1638.
// Stalls:
//   Each stage holds its content while the receiver stalls and still fills
//   when empty, so up to four requests are taken before i_in.ready drops.
module pressure_average_peak_tracker_top #(
    parameter int WINDOW = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pap_in_if.sink      i_in,
    pap_cfg_if.sink     i_cfg,
    pap_out_if.source   o_out
);
    import pap_pkg::*;

    localparam int SUM_W = PRESS_W + $clog2(WINDOW);

    logic [COUNT_W-1:0]         r_zero_count;
    logic                       w_sc_valid;
    logic                       w_sc_ready;
    t_scaled                    w_scaled;
    logic                       w_win_valid;
    logic                       w_win_ready;
    t_win_res                   w_win_res;
    logic signed [SUM_W-1:0]    w_win_sum;

    // Calibration register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_count <= ZERO_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_zero_count <= i_cfg.zero_count;
        end
    end

    // Offset correction and scaling.
    pap_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_zero_count (r_zero_count),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_high_byte  (i_in.high_byte),
        .i_low_byte   (i_in.low_byte),
        .i_read_ok    (i_in.read_ok),
        .o_valid      (w_sc_valid),
        .i_ready      (w_sc_ready),
        .o_scaled     (w_scaled)
    );

    // Window sum and peak hold.
    pap_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sc_valid),
        .o_ready  (w_sc_ready),
        .i_scaled (w_scaled),
        .o_valid  (w_win_valid),
        .i_ready  (w_win_ready),
        .o_res    (w_win_res),
        .o_sum    (w_win_sum)
    );

    // Window average and output register.
    pap_average #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_average (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_win_valid),
        .o_ready          (w_win_ready),
        .i_res            (w_win_res),
        .i_sum            (w_win_sum),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_pressure       (o_out.pressure),
        .o_window_average (o_out.window_average),
        .o_peak_pressure  (o_out.peak_pressure),
        .o_read_error     (o_out.read_error)
    );

endmodule

// File: rtl/pap_checker.sv
// Port-level checker for the pressure average and peak tracker, with its bind.
// Depends on pap_pkg and pressure_average_peak_tracker_top_assert.svh.
module pap_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [pap_pkg::PRESS_W-1:0]  i_pressure,
    input logic signed [pap_pkg::PRESS_W-1:0]  i_window_average,
    input logic [pap_pkg::PEAK_W-1:0]          i_peak_pressure,
    input logic                                i_read_error
);
    import pap_pkg::*;

`include "pressure_average_peak_tracker_top_assert.svh"

    // A stalled result keeps its payload.
    `PAP_ASSERT(a_out_hold,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pressure)
            && $stable(i_window_average) && $stable(i_peak_pressure)
            && $stable(i_read_error),
        "stalled result changed")

    // A failed read reports zero pressure.
    `PAP_ASSERT(a_err_zero, i_out_valid && i_read_error |-> i_pressure == '0,
        "failed read with nonzero pressure")

    // A good reading never exceeds the peak reported with it.
    `PAP_ASSERT(a_peak_bound,
        i_out_valid && !i_read_error |-> i_pressure <= $signed({1'b0, i_peak_pressure}),
        "pressure above peak")

    // Scaled pressure stays within the range the gain allows.
    `PAP_ASSERT(a_press_range,
        i_out_valid |-> i_pressure <= 16'sd32629 && i_pressure >= -16'sd32629,
        "pressure out of range")

    // Reset empties the pipeline.
    `PAP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind pressure_average_peak_tracker_top pap_checker u_pap_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_pressure       (o_out.pressure),
    .i_window_average (o_out.window_average),
    .i_peak_pressure  (o_out.peak_pressure),
    .i_read_error     (o_out.read_error)
);
